@@ hdl/sis_pkg.sv @@
// Package for the sorted integer set: codes, defaults and the controller command.
// No dependencies.
`default_nettype none
package sis_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam logic [1:0] FUNC_ADD      = 2'd0;
    localparam logic [1:0] FUNC_REMOVE   = 2'd1;
    localparam logic [1:0] FUNC_CONTAINS = 2'd2;
    localparam logic [1:0] FUNC_READ     = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    localparam logic [1:0] CLASS_16 = 2'd0;
    localparam logic [1:0] CLASS_32 = 2'd1;
    localparam logic [1:0] CLASS_64 = 2'd2;

    typedef struct packed {
        logic load;     // capture request on transfer
        logic compare;  // register per-cell compare results
        logic update;   // apply operation, load result registers
    } cmd_t;

endpackage
`default_nettype wire

@@ hdl/sis_ctrl.sv @@
// Controller for the sorted integer set: request/response sequencing.
// Depends on sis_pkg.
`default_nettype none
module sis_ctrl
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output sis_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_COMPARE = 3'b010,
        ST_UPDATE  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        cmd.load    = (state_reg == ST_IDLE) && req_valid;
        cmd.compare = (state_reg == ST_COMPARE);
        cmd.update  = (state_reg == ST_UPDATE) && (!rsp_valid_reg || !rsp_stall);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (req_valid) state_next = ST_COMPARE;
            ST_COMPARE: state_next = ST_UPDATE;
            ST_UPDATE:  if (cmd.update) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.update)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule
`default_nettype wire

@@ hdl/sis_datapath.sv @@
// Datapath for the sorted integer set: sorted cell row, compares, result registers.
// Depends on sis_pkg.
`default_nettype none
module sis_datapath
#(
    parameter int CAPACITY = sis_pkg::CAPACITY_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sis_pkg::cmd_t      cmd,
    input  wire logic        [1:0]  func,
    input  wire logic signed [63:0] value,
    input  wire logic        [5:0]  position,
    output logic                    present,
    output logic signed      [63:0] element,
    output logic             [6:0]  count,
    output logic             [1:0]  width_class,
    output logic             [1:0]  status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 6) ? CW : 6;
    localparam int RD = (CAPACITY < 64) ? CAPACITY : 64;

    logic        [1:0]  func_reg;
    logic signed [63:0] value_reg;
    logic        [5:0]  pos_reg;

    logic signed [63:0] cell_reg [CAPACITY];
    logic [CAPACITY-1:0] lt_reg, eq_reg;
    logic [CAPACITY-1:0] lt_now, eq_now, lt_prev;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]    wcls_reg, wcls_next;

    logic          present_reg;
    logic signed [63:0] element_reg;
    logic [1:0]    status_reg;

    logic        hit, full, in_range, do_ins, do_rem;
    logic [1:0]  vcls;
    logic signed [63:0] rd_data;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            value_reg <= value;
            pos_reg   <= position;
        end
    end

    // per-cell compare against the held request; cells past the count are masked
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            lt_now[i] = (CW'(i) < cnt_reg) && (cell_reg[i] < value_reg);
            eq_now[i] = (CW'(i) < cnt_reg) && (cell_reg[i] == value_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.compare)
        begin
            lt_reg <= lt_now;
            eq_reg <= eq_now;
        end
    end

    always_comb
    begin
        hit      = |eq_reg;
        full     = (cnt_reg == CW'(CAPACITY));
        in_range = (PW'(pos_reg) < PW'(cnt_reg));
        do_ins   = (func_reg == sis_pkg::FUNC_ADD) && !hit && !full;
        do_rem   = (func_reg == sis_pkg::FUNC_REMOVE) && hit;
        if (value_reg[63:15] == {49{value_reg[15]}})
            vcls = sis_pkg::CLASS_16;
        else if (value_reg[63:31] == {33{value_reg[31]}})
            vcls = sis_pkg::CLASS_32;
        else
            vcls = sis_pkg::CLASS_64;
        rd_data = '0;
        for (int i = 0; i < RD; i++)
            if (6'(i) == pos_reg)
                rd_data = cell_reg[i];
    end

    // insertion point is where the less-than thermometer ends
    if (CAPACITY > 1)
    begin : g_prev
        assign lt_prev = {lt_reg[CAPACITY-2:0], 1'b1};
    end
    else
    begin : g_prev1
        assign lt_prev = 1'b1;
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [63:0] below, above;
        if (g == 0)
        begin : g_lo
            assign below = value_reg;
        end
        else
        begin : g_mid
            assign below = cell_reg[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_hi
            assign above = cell_reg[g];
        end
        else
        begin : g_mid2
            assign above = cell_reg[g+1];
        end
        always_ff @(posedge clk)
        begin
            if (cmd.update && !lt_reg[g])
            begin
                if (do_ins)
                    cell_reg[g] <= lt_prev[g] ? value_reg : below;
                else if (do_rem)
                    cell_reg[g] <= above;
            end
        end
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        wcls_next = wcls_reg;
        if (do_ins)
        begin
            cnt_next = cnt_reg + CW'(1);
            if (vcls > wcls_reg)
                wcls_next = vcls;
        end
        else if (do_rem)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            wcls_reg <= sis_pkg::CLASS_16;
        end
        else if (cmd.update)
        begin
            cnt_reg  <= cnt_next;
            wcls_reg <= wcls_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            present_reg <= (func_reg != sis_pkg::FUNC_READ) && hit;
            element_reg <= ((func_reg == sis_pkg::FUNC_READ) && in_range) ? rd_data : '0;
            if (func_reg == sis_pkg::FUNC_READ && !in_range)
                status_reg <= sis_pkg::STAT_RANGE;
            else if (func_reg == sis_pkg::FUNC_ADD && !hit && full)
                status_reg <= sis_pkg::STAT_FULL;
            else
                status_reg <= sis_pkg::STAT_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            count       <= 7'(cnt_next);
            width_class <= wcls_next;
        end
    end

    assign present = present_reg;
    assign element = element_reg;
    assign status  = status_reg;

endmodule
`default_nettype wire

@@ hdl/sorted_integer_set.sv @@
// Top level of the sorted integer set: controller plus datapath.
// Depends on sis_pkg, sis_ctrl, sis_datapath.
//
// Usage: a request (func, value, position) transfers when req_valid is high
// and req_stall low. func selects add, remove, contains or read-at-index.
// The result (present, element, count, width_class, status) transfers when
// rsp_valid is high and rsp_stall low.
// Each request passes through capture, a compare step in which every cell
// compares itself to the value in parallel, and an update step that shifts
// the cell row by one place and loads the result register. A new request is
// taken only once the update has loaded the result of the last one, so
// requests never overlap while the receiver takes results.
// If the receiver stalls, the held result stays stable and the next request
// waits in its update cycle until the result register frees up.
// Reset empties the set (count zero) and sets the width class to 16 bit;
// cell contents are not cleared, cells at or past the count are never read.
`default_nettype none
module sorted_integer_set
#(
    parameter int CAPACITY = sis_pkg::CAPACITY_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire logic        [1:0]  func,
    input  wire logic signed [63:0] value,
    input  wire logic        [5:0]  position,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output logic                    present,
    output logic signed      [63:0] element,
    output logic             [6:0]  count,
    output logic             [1:0]  width_class,
    output logic             [1:0]  status
);

    sis_pkg::cmd_t cmd;

    sis_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    sis_datapath #(.CAPACITY(CAPACITY)) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .func        (func),
        .value       (value),
        .position    (position),
        .present     (present),
        .element     (element),
        .count       (count),
        .width_class (width_class),
        .status      (status)
    );

endmodule
`default_nettype wire

@@ hdl/sis_checker.sv @@
// Port-level checks for the sorted integer set, bound to the top level.
// Depends on sis_pkg and sorted_integer_set.
`default_nettype none
module sis_checker
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire logic              req_stall,
    input  wire logic              rsp_valid,
    input  wire logic              rsp_stall,
    input  wire logic              present,
    input  wire logic       [63:0] element,
    input  wire logic       [1:0]  width_class,
    input  wire logic       [1:0]  status
);

    // one request at a time: after a transfer the request side is busy
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request taken while busy");

    a_range_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == sis_pkg::STAT_RANGE) |-> (!present && element == 64'd0))
        else $error("out-of-range read carries data");

    a_full_absent: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == sis_pkg::STAT_FULL) |-> !present)
        else $error("full status on a present value");

    a_class_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && $past(rsp_valid)) |-> (width_class >= $past(width_class)))
        else $error("width class fell");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(element) && $stable(status)))
        else $error("stalled result changed");

endmodule

bind sorted_integer_set sis_checker u_sis_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .present     (present),
    .element     (element),
    .width_class (width_class),
    .status      (status)
);
`default_nettype wire

@@ test/tb.sv @@
// Testbench for sorted_integer_set: drives requests, predicts each result
// from a sorted model of the set, checks results in order. Depends on sis_pkg.
`timescale 1ns / 1ps
module tb;

    localparam int CAP = 64;

    typedef struct packed {
        logic [1:0]  fn;
        logic [63:0] val;
        logic [5:0]  pos;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [63:0] elem;
        logic [6:0]  cnt;
        logic [1:0]  wcls;
        logic [1:0]  stat;
    } rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    logic [1:0] func = sis_pkg::FUNC_ADD;
    logic signed [63:0] value = '0;
    logic [5:0] position = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    logic present;
    logic signed [63:0] element;
    logic [6:0] count;
    logic [1:0] width_class;
    logic [1:0] status;

    sorted_integer_set u_top (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .func(func), .value(value), .position(position),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .present(present), .element(element), .count(count),
        .width_class(width_class), .status(status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    logic signed [63:0] set_vals[$];
    logic [1:0] cur_class = sis_pkg::CLASS_16;
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    bit req_taken = 0;
    bit stim_done = 0;

    function automatic logic [1:0] class_of(logic signed [63:0] v);
        if (v >= -64'sd32768 && v <= 64'sd32767)
            return sis_pkg::CLASS_16;
        if (v >= -64'sd2147483648 && v <= 64'sd2147483647)
            return sis_pkg::CLASS_32;
        return sis_pkg::CLASS_64;
    endfunction

    function automatic rsp_t predict_set_op(req_t r);
        rsp_t o;
        int slot;
        bit hit;
        o = '0;
        slot = 0;
        while (slot < set_vals.size() && set_vals[slot] < $signed(r.val))
            slot++;
        hit = slot < set_vals.size() && set_vals[slot] == $signed(r.val);
        case (r.fn)
            sis_pkg::FUNC_READ:
                if (r.pos < set_vals.size())
                    o.elem = set_vals[r.pos];
                else
                    o.stat = sis_pkg::STAT_RANGE;
            sis_pkg::FUNC_ADD:
                if (hit)
                    o.hit = 1'b1;
                else if (set_vals.size() >= CAP)
                    o.stat = sis_pkg::STAT_FULL;
                else
                begin
                    set_vals.insert(slot, r.val);
                    if (class_of(r.val) > cur_class)
                        cur_class = class_of(r.val);
                end
            sis_pkg::FUNC_REMOVE:
                if (hit)
                begin
                    o.hit = 1'b1;
                    set_vals.delete(slot);
                end
            default:
                o.hit = hit;
        endcase
        o.cnt = 7'(set_vals.size());
        o.wcls = cur_class;
        return o;
    endfunction

    // driver: new transfer offered at falling edge once previous one is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_taken)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_t r;
                    r = pending_reqs.pop_front();
                    func <= r.fn;
                    value <= r.val;
                    position <= r.pos;
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // receiver: long hold-off counted here, random stalls otherwise
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cycles > 0)
            begin
                rsp_stall <= 1'b1;
                hold_cycles <= hold_cycles - 1;
            end
            else
                rsp_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // request and result monitor
    always @(posedge clk)
    begin
        req_taken <= rst_n && req_valid && !req_stall;
        if (rst_n && req_valid && !req_stall)
            expected_rsps.insert(expected_rsps.size(),
                                 predict_set_op({func, value, position}));
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("unexpected result");
                errors++;
            end
            else
            begin
                rsp_t e;
                e = expected_rsps.pop_front();
                if (present !== e.hit)
                begin
                    $error("present exp %0d got %0d", e.hit, present);
                    errors++;
                end
                if (element !== e.elem)
                begin
                    $error("element exp %0d got %0d", $signed(e.elem), element);
                    errors++;
                end
                if (count !== e.cnt)
                begin
                    $error("count exp %0d got %0d", e.cnt, count);
                    errors++;
                end
                if (width_class !== e.wcls)
                begin
                    $error("width_class exp %0d got %0d", e.wcls, width_class);
                    errors++;
                end
                if (status !== e.stat)
                begin
                    $error("status exp %0d got %0d", e.stat, status);
                    errors++;
                end
            end
        end
    end

    logic signed [63:0] pool[$];

    function automatic logic [63:0] rand_val();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(5))
            0: v = 64'($signed(16'(v)));
            1: v = 64'($signed(32'(v)));
            2: v = 64'($signed(6'(v)));
            default: ;
        endcase
        return v;
    endfunction

    task automatic push_req(logic [1:0] f, logic [63:0] v, logic [5:0] p);
        pending_reqs.insert(pending_reqs.size(), '{fn: f, val: v, pos: p});
        if (f == sis_pkg::FUNC_ADD)
            pool.insert(pool.size(), v);
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic random_phase(int n);
        logic [63:0] v;
        for (int i = 0; i < n; i++)
        begin
            v = (pool.size() > 0 && $urandom_range(1)) ?
                pool[$urandom_range(pool.size() - 1)] : rand_val();
            push_req(2'($urandom_range(3)), v, 6'($urandom));
        end
        drain();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // directed: empty reads, extremes, duplicates, absent ops, growth
        push_req(sis_pkg::FUNC_READ, '0, 6'd0);
        push_req(sis_pkg::FUNC_REMOVE, 64'd5, '0);
        push_req(sis_pkg::FUNC_CONTAINS, 64'd5, 6'd63);
        push_req(sis_pkg::FUNC_ADD, 64'd7, '0);
        push_req(sis_pkg::FUNC_ADD, 64'd7, '0);
        push_req(sis_pkg::FUNC_ADD, -64'sd32768, '0);
        push_req(sis_pkg::FUNC_ADD, 64'd32768, '0);
        push_req(sis_pkg::FUNC_ADD, 64'h8000_0000_0000_0000, '0);
        push_req(sis_pkg::FUNC_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 6'h3f);
        push_req(sis_pkg::FUNC_READ, '0, 6'd0);
        push_req(sis_pkg::FUNC_READ, '0, 6'd4);
        push_req(sis_pkg::FUNC_READ, '0, 6'd5);
        push_req(sis_pkg::FUNC_READ, '0, 6'd63);
        push_req(sis_pkg::FUNC_CONTAINS, 64'h7FFF_FFFF_FFFF_FFFF, '0);
        push_req(sis_pkg::FUNC_REMOVE, 64'h8000_0000_0000_0000, '0);
        push_req(sis_pkg::FUNC_REMOVE, 64'h8000_0000_0000_0000, '0);
        push_req(sis_pkg::FUNC_READ, '0, 6'd0);
        drain();
        // fill to capacity, refused add, duplicate add while full
        for (int i = 0; i < CAP; i++)
            push_req(sis_pkg::FUNC_ADD, 64'(i * 3 - 90), '0);
        push_req(sis_pkg::FUNC_ADD, 64'd1, '0);
        push_req(sis_pkg::FUNC_ADD, 64'h1_0000_0000_0000, '0);
        push_req(sis_pkg::FUNC_ADD, -64'sd90, '0);
        push_req(sis_pkg::FUNC_READ, '0, 6'd63);
        // receiver holds off while sender keeps offering
        hold_cycles = 200;
        drain();
        for (int i = 0; i < 4; i++)
        begin
            case (i)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            random_phase(200);
        end
        // thin the set with removes of a random three in four added values, then random again
        send_idle_pct = 0;
        recv_stall_pct = 0;
        foreach (pool[k])
            if ($urandom_range(3) != 0)
                push_req(sis_pkg::FUNC_REMOVE, pool[k], '0);
        pool.delete();
        random_phase(100);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end
endmodule
